/* hw/rtl/swc_pkg.sv */
// Shared types and constants for the waterfall spectrum colormap.
`timescale 1ns / 1ps
`default_nettype none

package swc_pkg;

    localparam int QW      = 16;                  // Q7.8 level width
    localparam int ScaleW  = 7;
    localparam int WeightW = ScaleW + 1;          // signed blend weight
    localparam int OffW    = QW + 1;              // global max plus 5 dB
    localparam int ProdW   = OffW + WeightW;
    localparam int SumW    = ProdW + 1;
    localparam int DiffW   = SumW + 1;
    localparam int DenW    = 23;                  // positive range (x100) fits here
    localparam int NumW    = DenW + 8;            // numerator times 255
    localparam int IdxW    = 8;
    localparam int SegW    = 6;                   // offset inside a ramp segment
    localparam int XW      = SegW + 7;            // offset times 128

    localparam int InDataW  = 5 * QW;
    localparam int OutDataW = 4 * IdxW;

    localparam logic [ScaleW-1:0]      MaxPct = 7'd100;
    localparam logic signed [OffW-1:0] FiveDb = 17'sd1280;
    localparam logic [WeightW-1:0]     Hundred = 8'd100;

    localparam logic [IdxW-1:0] Knot1 = 8'd51;
    localparam logic [IdxW-1:0] Knot2 = 8'd102;
    localparam logic [IdxW-1:0] Knot3 = 8'd153;
    localparam logic [IdxW-1:0] Knot4 = 8'd204;
    localparam logic [IdxW-1:0] DarkBlue = 8'd128;
    localparam logic [IdxW-1:0] Full     = 8'd255;

    // floor(x / 51) = (x * RecipMul) >> RecipSh for x up to 6528
    localparam int RecipMulW = 15;
    localparam logic [RecipMulW-1:0] RecipMul = 15'd20561;
    localparam int RecipSh  = 20;
    localparam int RecipPW  = XW + RecipMulW;

    typedef enum logic [2:0] {
        SEG_BLACK_DKBLUE,
        SEG_DKBLUE_BLUE,
        SEG_BLUE_YELLOW,
        SEG_YELLOW_RED,
        SEG_RED_WHITE
    } swc_seg_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic sat;     // index forced to full scale
    } swc_side_t;

endpackage

`default_nettype wire

/* hw/rtl/swc_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module swc_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire swc_pkg::swc_side_t         in_side,
    input  wire logic [swc_pkg::NumW-1:0]   in_num,
    input  wire logic [swc_pkg::DenW-1:0]   in_den,
    output swc_pkg::swc_side_t              out_side,
    output logic [swc_pkg::IdxW-1:0]        out_quo
);

    localparam int Stages = swc_pkg::IdxW;

    swc_pkg::swc_side_t            side_reg [Stages];
    logic [swc_pkg::NumW-1:0]      rem_reg  [Stages];
    logic [swc_pkg::DenW-1:0]      den_reg  [Stages];
    logic [swc_pkg::IdxW-1:0]      quo_reg  [Stages];

    for (genvar j = 0; j < Stages; j++) begin : g_stage
        localparam int Sh = Stages - 1 - j;

        swc_pkg::swc_side_t        side_in;
        logic [swc_pkg::NumW-1:0]  rem_in;
        logic [swc_pkg::DenW-1:0]  den_in;
        logic [swc_pkg::IdxW-1:0]  quo_in;
        logic [swc_pkg::NumW-1:0]  dsh;
        logic                      ge;
        logic [swc_pkg::NumW-1:0]  rem_next;
        logic [swc_pkg::IdxW-1:0]  quo_next;

        if (j == 0) begin : g_first
            assign side_in = in_side;
            assign rem_in  = in_num;
            assign den_in  = in_den;
            assign quo_in  = '0;
        end
        else begin : g_rest
            assign side_in = side_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign den_in  = den_reg[j-1];
            assign quo_in  = quo_reg[j-1];
        end

        assign dsh      = swc_pkg::NumW'(den_in) << Sh;
        assign ge       = (rem_in >= dsh);
        assign rem_next = ge ? (rem_in - dsh) : rem_in;
        assign quo_next = {quo_in[swc_pkg::IdxW-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[j] <= '0;
            end
            else if (en)
            begin
                side_reg[j] <= side_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= rem_next;
                den_reg[j] <= den_in;
                quo_reg[j] <= quo_next;
            end
        end
    end

    assign out_side = side_reg[Stages-1];
    assign out_quo  = side_reg[Stages-1].sat ? swc_pkg::Full : quo_reg[Stages-1];

endmodule

`default_nettype wire

/* hw/rtl/swc_ramp.sv */
// Five-segment color ramp lookup, two register stages.
`timescale 1ns / 1ps
`default_nettype none

module swc_ramp (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire swc_pkg::swc_side_t      in_side,
    input  wire logic [swc_pkg::IdxW-1:0] in_idx,
    output swc_pkg::swc_side_t           out_side,
    output logic [swc_pkg::IdxW-1:0]     red,
    output logic [swc_pkg::IdxW-1:0]     green,
    output logic [swc_pkg::IdxW-1:0]     blue,
    output logic [swc_pkg::IdxW-1:0]     level_index
);

    // stage A: segment and offset
    swc_pkg::swc_side_t          a_side_reg;
    swc_pkg::swc_seg_t           a_seg_reg, a_seg_next;
    logic [swc_pkg::IdxW-1:0]    a_idx_reg;
    logic [swc_pkg::IdxW-1:0]    a_five_reg, a_five_next;
    logic [swc_pkg::XW-1:0]      a_x128_reg, a_x128_next;
    logic [swc_pkg::XW-1:0]      a_x127_reg, a_x127_next;
    logic [swc_pkg::IdxW-1:0]    knot;
    logic [swc_pkg::IdxW-1:0]    off_full;
    logic [swc_pkg::SegW-1:0]    off;

    always_comb
    begin
        if (in_idx >= swc_pkg::Knot4)
        begin
            a_seg_next = swc_pkg::SEG_RED_WHITE;
            knot       = swc_pkg::Knot4;
        end
        else if (in_idx >= swc_pkg::Knot3)
        begin
            a_seg_next = swc_pkg::SEG_YELLOW_RED;
            knot       = swc_pkg::Knot3;
        end
        else if (in_idx >= swc_pkg::Knot2)
        begin
            a_seg_next = swc_pkg::SEG_BLUE_YELLOW;
            knot       = swc_pkg::Knot2;
        end
        else if (in_idx >= swc_pkg::Knot1)
        begin
            a_seg_next = swc_pkg::SEG_DKBLUE_BLUE;
            knot       = swc_pkg::Knot1;
        end
        else
        begin
            a_seg_next = swc_pkg::SEG_BLACK_DKBLUE;
            knot       = '0;
        end
    end

    assign off_full    = in_idx - knot;
    assign off         = off_full[swc_pkg::SegW-1:0];
    assign a_five_next = swc_pkg::IdxW'({off, 2'b00}) + swc_pkg::IdxW'(off);
    assign a_x128_next = {off, 7'b0};
    assign a_x127_next = a_x128_next - swc_pkg::XW'(off);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_side_reg <= '0;
        end
        else if (en)
        begin
            a_side_reg <= in_side;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_seg_reg  <= a_seg_next;
            a_idx_reg  <= in_idx;
            a_five_reg <= a_five_next;
            a_x128_reg <= a_x128_next;
            a_x127_reg <= a_x127_next;
        end
    end

    // stage B: divide by 51 via reciprocal, pick components
    swc_pkg::swc_side_t          b_side_reg;
    logic [swc_pkg::IdxW-1:0]    b_red_reg, b_red_next;
    logic [swc_pkg::IdxW-1:0]    b_green_reg, b_green_next;
    logic [swc_pkg::IdxW-1:0]    b_blue_reg, b_blue_next;
    logic [swc_pkg::IdxW-1:0]    b_idx_reg;
    logic [swc_pkg::RecipPW-1:0] p128, p127;
    logic [swc_pkg::IdxW-1:0]    q128, q127;

    assign p128 = swc_pkg::RecipPW'(a_x128_reg) * swc_pkg::RecipPW'(swc_pkg::RecipMul);
    assign p127 = swc_pkg::RecipPW'(a_x127_reg) * swc_pkg::RecipPW'(swc_pkg::RecipMul);
    assign q128 = p128[swc_pkg::RecipSh +: swc_pkg::IdxW];
    assign q127 = p127[swc_pkg::RecipSh +: swc_pkg::IdxW];

    always_comb
    begin
        unique case (a_seg_reg)
            swc_pkg::SEG_BLACK_DKBLUE:
            begin
                b_red_next   = '0;
                b_green_next = '0;
                b_blue_next  = q128;
            end
            swc_pkg::SEG_DKBLUE_BLUE:
            begin
                b_red_next   = '0;
                b_green_next = '0;
                b_blue_next  = swc_pkg::DarkBlue + q127;
            end
            swc_pkg::SEG_BLUE_YELLOW:
            begin
                b_red_next   = a_five_reg;
                b_green_next = a_five_reg;
                b_blue_next  = swc_pkg::Full - a_five_reg;
            end
            swc_pkg::SEG_YELLOW_RED:
            begin
                b_red_next   = swc_pkg::Full;
                b_green_next = swc_pkg::Full - a_five_reg;
                b_blue_next  = '0;
            end
            swc_pkg::SEG_RED_WHITE:
            begin
                b_red_next   = swc_pkg::Full;
                b_green_next = a_five_reg;
                b_blue_next  = a_five_reg;
            end
            default:
            begin
                b_red_next   = '0;
                b_green_next = '0;
                b_blue_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_side_reg <= '0;
        end
        else if (en)
        begin
            b_side_reg <= a_side_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_red_reg   <= b_red_next;
            b_green_reg <= b_green_next;
            b_blue_reg  <= b_blue_next;
            b_idx_reg   <= a_idx_reg;
        end
    end

    assign out_side    = b_side_reg;
    assign red         = b_red_reg;
    assign green       = b_green_reg;
    assign blue        = b_blue_reg;
    assign level_index = b_idx_reg;

endmodule

`default_nettype wire

/* hw/rtl/spectrum_waterfall_colormap.sv */
// Top level: waterfall spectrum colormap, spectrum bin in, RGB pixel out.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    s_tdata: bin_value, global_max, global_min,
//                                     local_max, local_min; s_tlast: row_last
//  m_*      out  m_tvalid/m_tready    m_tdata: red, green, blue, level_index;
//                                     m_tlast: pixel_last
//  cfg_*    in   cfg_we               cfg_wdata: scale_percent
//
// One transaction per clock sustained unless m_tready stalls the output; 4 limit/normalize
// stages, 8 divider stages, 2 ramp stages.
// Reset clears all valid bits and sets scale_percent to 0.
// A stall on m_tready freezes the whole pipeline; s_tready drops in the same cycle.
// Bins with an empty or negative range are dropped at the normalize stage.
`timescale 1ns / 1ps
`default_nettype none

module spectrum_waterfall_colormap (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [swc_pkg::ScaleW-1:0]      cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // bin_value, global_max, global_min, local_max, local_min (16 bits each)
    input  wire logic [swc_pkg::InDataW-1:0]     s_tdata,
    input  wire logic                            s_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // red, green, blue, level_index (8 bits each)
    output logic [swc_pkg::OutDataW-1:0]         m_tdata,
    output logic                                 m_tlast
);

    localparam int QW = swc_pkg::QW;

    logic adv;

    // scale register, stored saturated
    logic [swc_pkg::ScaleW-1:0] scale_reg, scale_next;

    assign scale_next = (cfg_wdata > swc_pkg::MaxPct) ? swc_pkg::MaxPct : cfg_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= '0;
        end
        else if (cfg_we)
        begin
            scale_reg <= scale_next;
        end
    end

    // stage 1: weighted products
    logic signed [QW-1:0]                 bin_in, gmax_in, gmin_in, lmax_in, lmin_in;
    logic signed [swc_pkg::OffW-1:0]      gmax_off;
    logic signed [swc_pkg::WeightW-1:0]   w_glob, w_loc, w_hundred;
    swc_pkg::swc_side_t                   s1_side_reg, s1_side_next;
    logic signed [swc_pkg::ProdW-1:0]     s1_tg_reg, s1_tg_next;
    logic signed [swc_pkg::ProdW-1:0]     s1_tl_reg, s1_tl_next;
    logic signed [swc_pkg::ProdW-1:0]     s1_bg_reg, s1_bg_next;
    logic signed [swc_pkg::ProdW-1:0]     s1_bl_reg, s1_bl_next;
    logic signed [swc_pkg::ProdW-1:0]     s1_bin_reg, s1_bin_next;

    assign bin_in  = s_tdata[0*QW +: QW];
    assign gmax_in = s_tdata[1*QW +: QW];
    assign gmin_in = s_tdata[2*QW +: QW];
    assign lmax_in = s_tdata[3*QW +: QW];
    assign lmin_in = s_tdata[4*QW +: QW];

    assign gmax_off  = swc_pkg::OffW'(gmax_in) + swc_pkg::FiveDb;
    assign w_loc     = signed'({1'b0, scale_reg});
    assign w_glob    = signed'(swc_pkg::Hundred - swc_pkg::WeightW'(scale_reg));
    assign w_hundred = signed'(swc_pkg::Hundred);

    assign s1_side_next = '{valid: s_tvalid, last: s_tlast, sat: 1'b0};
    assign s1_tg_next   = swc_pkg::ProdW'(gmax_off) * swc_pkg::ProdW'(w_glob);
    assign s1_tl_next   = swc_pkg::ProdW'(lmax_in) * swc_pkg::ProdW'(w_loc);
    assign s1_bg_next   = swc_pkg::ProdW'(gmin_in) * swc_pkg::ProdW'(w_glob);
    assign s1_bl_next   = swc_pkg::ProdW'(lmin_in) * swc_pkg::ProdW'(w_loc);
    assign s1_bin_next  = swc_pkg::ProdW'(bin_in) * swc_pkg::ProdW'(w_hundred);

    // stage 2: blended limits
    swc_pkg::swc_side_t                s2_side_reg;
    logic signed [swc_pkg::SumW-1:0]   s2_top_reg, s2_top_next;
    logic signed [swc_pkg::SumW-1:0]   s2_bot_reg, s2_bot_next;
    logic signed [swc_pkg::SumW-1:0]   s2_bin_reg, s2_bin_next;

    assign s2_top_next = swc_pkg::SumW'(s1_tg_reg) + swc_pkg::SumW'(s1_tl_reg);
    assign s2_bot_next = swc_pkg::SumW'(s1_bg_reg) + swc_pkg::SumW'(s1_bl_reg);
    assign s2_bin_next = swc_pkg::SumW'(s1_bin_reg);

    // stage 3: range and offset
    swc_pkg::swc_side_t                s3_side_reg;
    logic signed [swc_pkg::DiffW-1:0]  s3_range_reg, s3_range_next;
    logic signed [swc_pkg::DiffW-1:0]  s3_num_reg, s3_num_next;

    assign s3_range_next = swc_pkg::DiffW'(s2_top_reg) - swc_pkg::DiffW'(s2_bot_reg);
    assign s3_num_next   = swc_pkg::DiffW'(s2_bin_reg) - swc_pkg::DiffW'(s2_bot_reg);

    // stage 4: classify, scale numerator by 255
    swc_pkg::swc_side_t                s4_side_reg, s4_side_next;
    logic [swc_pkg::NumW-1:0]          s4_num_reg, s4_num_next;
    logic [swc_pkg::DenW-1:0]          s4_den_reg;
    logic                              range_pos, num_low, num_high;
    logic [swc_pkg::DenW-1:0]          num_lo, range_lo;

    assign range_pos = (s3_range_reg > 0);
    assign num_low   = (s3_num_reg <= 0);
    assign num_high  = (s3_num_reg >= s3_range_reg);
    assign num_lo    = s3_num_reg[swc_pkg::DenW-1:0];
    assign range_lo  = s3_range_reg[swc_pkg::DenW-1:0];

    assign s4_side_next = '{valid: s3_side_reg.valid && range_pos,
                            last:  s3_side_reg.last,
                            sat:   num_high};
    assign s4_num_next  = (num_low || num_high) ? '0
                        : ({num_lo, 8'b0} - swc_pkg::NumW'(num_lo));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_side_reg <= '0;
            s2_side_reg <= '0;
            s3_side_reg <= '0;
            s4_side_reg <= '0;
        end
        else if (adv)
        begin
            s1_side_reg <= s1_side_next;
            s2_side_reg <= s1_side_reg;
            s3_side_reg <= s2_side_reg;
            s4_side_reg <= s4_side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_tg_reg    <= s1_tg_next;
            s1_tl_reg    <= s1_tl_next;
            s1_bg_reg    <= s1_bg_next;
            s1_bl_reg    <= s1_bl_next;
            s1_bin_reg   <= s1_bin_next;
            s2_top_reg   <= s2_top_next;
            s2_bot_reg   <= s2_bot_next;
            s2_bin_reg   <= s2_bin_next;
            s3_range_reg <= s3_range_next;
            s3_num_reg   <= s3_num_next;
            s4_num_reg   <= s4_num_next;
            s4_den_reg   <= range_lo;
        end
    end

    // divider and ramp
    swc_pkg::swc_side_t         div_side;
    logic [swc_pkg::IdxW-1:0]   div_quo;
    swc_pkg::swc_side_t         out_side;
    logic [swc_pkg::IdxW-1:0]   red, green, blue, level_index;

    swc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_side  (s4_side_reg),
        .in_num   (s4_num_reg),
        .in_den   (s4_den_reg),
        .out_side (div_side),
        .out_quo  (div_quo)
    );

    swc_ramp u_ramp (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (adv),
        .in_side     (div_side),
        .in_idx      (div_quo),
        .out_side    (out_side),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .level_index (level_index)
    );

    assign adv      = !out_side.valid || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_side.valid;
    assign m_tlast  = out_side.last;
    assign m_tdata  = {level_index, blue, green, red};

    // checks
    a_scale_sat: assert property (@(posedge clk) disable iff (!rst_n)
        scale_reg <= swc_pkg::MaxPct)
        else $error("scale register above 100");

    a_full_white: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (level_index == swc_pkg::Full)
        |-> (red == swc_pkg::Full) && (green == swc_pkg::Full) && (blue == swc_pkg::Full))
        else $error("full-scale index not white");

    a_zero_black: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (level_index == '0) |-> (red == '0) && (green == '0) && (blue == '0))
        else $error("zero index not black");

    a_red_ramp: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (red != '0) && (red != swc_pkg::Full)
        |-> (level_index >= swc_pkg::Knot2) && (level_index < swc_pkg::Knot3))
        else $error("partial red outside blue-yellow segment");

    a_drop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s3_side_reg.valid && !range_pos |=> !s4_side_reg.valid)
        else $error("bin with empty range entered divider");

endmodule

`default_nettype wire

/* tb/tb.sv */
// Testbench for spectrum_waterfall_colormap: random stream traffic, self-checking.
`timescale 1ns / 1ps

module tb;

    localparam int PIPE_LAT     = 14;
    localparam int DRAIN_CYCLES = 3 * PIPE_LAT;
    localparam int LIMIT_CYCLES = 400000;
    localparam int MAX_REPORTS  = 10;
    localparam int RAMP_STEP    = int'(swc_pkg::Knot1);
    localparam int LAST_SEG     = 4;
    localparam int PHASE_BINS   = 85;

    typedef enum int {CH_RED, CH_GREEN, CH_BLUE} chan_t;

    typedef struct {
        logic signed [swc_pkg::QW-1:0] level;
        logic signed [swc_pkg::QW-1:0] gmax;
        logic signed [swc_pkg::QW-1:0] gmin;
        logic signed [swc_pkg::QW-1:0] lmax;
        logic signed [swc_pkg::QW-1:0] lmin;
        logic                          row_last;
    } bin_t;

    typedef struct packed {
        logic [swc_pkg::IdxW-1:0] red;
        logic [swc_pkg::IdxW-1:0] green;
        logic [swc_pkg::IdxW-1:0] blue;
        logic [swc_pkg::IdxW-1:0] lvl_idx;
        logic                     last;
    } pixel_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         cfg_we;
    logic [swc_pkg::ScaleW-1:0]   cfg_wdata;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [swc_pkg::InDataW-1:0]  s_tdata;   // bin_value, global_max, global_min, local_max, local_min
    logic                         s_tlast;   // row_last
    logic                         m_tvalid;
    logic                         m_tready;
    logic [swc_pkg::OutDataW-1:0] m_tdata;   // red, green, blue, level_index
    logic                         m_tlast;   // pixel_last

    bin_t   bin_q[$];
    pixel_t pixel_q[$];
    bin_t   cur_bin;
    pixel_t exp_px;
    pixel_t got_px;
    pixel_t want_px;

    logic [swc_pkg::ScaleW-1:0] scale_now = '0;
    bit  src_taken = 0;
    bit  settle = 0;
    int  src_gap = 0;
    int  snk_gap = 0;
    int  src_idle_pct = 0;
    int  snk_idle_pct = 0;
    int  cycles = 0;
    int  n_bins = 0;
    int  n_pixels = 0;
    int  n_dropped = 0;
    int  n_bad = 0;
    int  n_cfg = 0;

    spectrum_waterfall_colormap u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    function automatic logic signed [swc_pkg::QW-1:0] clip16(input int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    function automatic int knot_color(input int stop, input chan_t ch);
        case (stop)
            1: return (ch == CH_BLUE) ? int'(swc_pkg::DarkBlue) : 0;
            2: return (ch == CH_BLUE) ? int'(swc_pkg::Full) : 0;
            3: return (ch == CH_BLUE) ? 0 : int'(swc_pkg::Full);
            4: return (ch == CH_RED) ? int'(swc_pkg::Full) : 0;
            5: return int'(swc_pkg::Full);
            default: return 0;
        endcase
    endfunction

    function automatic logic [swc_pkg::IdxW-1:0] ramp_channel(input int idx, input chan_t ch);
        int seg;
        int d;
        int c0;
        int c1;
        seg = idx / RAMP_STEP;
        if (seg > LAST_SEG)
            seg = LAST_SEG;
        d  = idx - seg * RAMP_STEP;
        c0 = knot_color(seg, ch);
        c1 = knot_color(seg + 1, ch);
        return swc_pkg::IdxW'((RAMP_STEP * c0 + d * (c1 - c0)) / RAMP_STEP);
    endfunction

    // Limits are kept times 100 so the blend stays exact.
    function automatic bit predict_pixel(input bin_t b, input logic [swc_pkg::ScaleW-1:0] pct,
                                         output pixel_t px);
        longint w;
        longint hun;
        longint top;
        longint bot;
        longint span;
        longint num;
        int     idx;
        hun  = longint'(swc_pkg::Hundred);
        w    = (pct > swc_pkg::MaxPct) ? longint'(swc_pkg::MaxPct) : longint'(pct);
        top  = (longint'(b.gmax) + longint'(swc_pkg::FiveDb)) * (hun - w)
               + longint'(b.lmax) * w;
        bot  = longint'(b.gmin) * (hun - w) + longint'(b.lmin) * w;
        span = top - bot;
        px   = '0;
        if (span <= 0)
            return 0;
        num = longint'(b.level) * hun - bot;
        if (num <= 0)
            idx = 0;
        else if (num >= span)
            idx = int'(swc_pkg::Full);
        else
            idx = int'((num * longint'(swc_pkg::Full)) / span);
        px.red     = ramp_channel(idx, CH_RED);
        px.green   = ramp_channel(idx, CH_GREEN);
        px.blue    = ramp_channel(idx, CH_BLUE);
        px.lvl_idx = swc_pkg::IdxW'(idx);
        px.last    = b.row_last;
        return 1;
    endfunction

    // sender
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || src_taken)
            begin
                if (src_gap > 0)
                begin
                    src_gap = src_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
                begin
                    src_gap = $urandom_range(12, 0);
                    s_tvalid <= 1'b0;
                end
                else if (bin_q.size() != 0)
                begin
                    cur_bin = bin_q.pop_front();
                    s_tdata  <= {cur_bin.lmin, cur_bin.lmax, cur_bin.gmin, cur_bin.gmax,
                                 cur_bin.level};
                    s_tlast  <= cur_bin.row_last;
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            src_taken = 0;
        end
    end

    // receiver backpressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (settle)
            begin
                snk_gap = 0;
                m_tready <= 1'b1;
            end
            else if (snk_gap > 0)
            begin
                snk_gap = snk_gap - 1;
                m_tready <= 1'b0;
            end
            else if (snk_idle_pct != 0 && $urandom_range(99) < snk_idle_pct)
            begin
                snk_gap = $urandom_range(12, 0);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // input transactions -> expected pixels
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            src_taken = 1;
            n_bins = n_bins + 1;
            if (predict_pixel(cur_bin, scale_now, exp_px))
                pixel_q.push_back(exp_px);
            else
                n_dropped = n_dropped + 1;
        end
    end

    // output transactions checked in order
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_px.red     = m_tdata[swc_pkg::IdxW-1:0];
            got_px.green   = m_tdata[2*swc_pkg::IdxW-1:swc_pkg::IdxW];
            got_px.blue    = m_tdata[3*swc_pkg::IdxW-1:2*swc_pkg::IdxW];
            got_px.lvl_idx = m_tdata[4*swc_pkg::IdxW-1:3*swc_pkg::IdxW];
            got_px.last    = m_tlast;
            if (pixel_q.size() == 0)
            begin
                n_bad = n_bad + 1;
                if (n_bad <= MAX_REPORTS)
                    $display("pixel %0d: unexpected, got r=%0d g=%0d b=%0d idx=%0d last=%0d",
                             n_pixels, got_px.red, got_px.green, got_px.blue,
                             got_px.lvl_idx, got_px.last);
            end
            else
            begin
                want_px = pixel_q.pop_front();
                if (got_px !== want_px)
                begin
                    n_bad = n_bad + 1;
                    if (n_bad <= MAX_REPORTS)
                    begin
                        $display("pixel %0d: expected r=%0d g=%0d b=%0d idx=%0d last=%0d",
                                 n_pixels, want_px.red, want_px.green, want_px.blue,
                                 want_px.lvl_idx, want_px.last);
                        $display("pixel %0d: got      r=%0d g=%0d b=%0d idx=%0d last=%0d",
                                 n_pixels, got_px.red, got_px.green, got_px.blue,
                                 got_px.lvl_idx, got_px.last);
                    end
                end
            end
            n_pixels = n_pixels + 1;
        end
    end

    task automatic push_bin(input int level, input int gmax, input int gmin,
                            input int lmax, input int lmin, input bit last);
        bin_t b;
        b.level    = clip16(level);
        b.gmax     = clip16(gmax);
        b.gmin     = clip16(gmin);
        b.lmax     = clip16(lmax);
        b.lmin     = clip16(lmin);
        b.row_last = last;
        bin_q.push_back(b);
    endtask

    task automatic wait_drained();
        while (bin_q.size() != 0 || s_tvalid || pixel_q.size() != 0)
            @(posedge clk);
        settle = 1;
        repeat (DRAIN_CYCLES) @(posedge clk);
        settle = 0;
    endtask

    task automatic write_scale(input logic [swc_pkg::ScaleW-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        scale_now = v;
        n_cfg = n_cfg + 1;
    endtask

    // Mostly sane limit sets with the bin near the range, some near-empty
    // ranges and some raw noise.
    task automatic run_phase(input logic [swc_pkg::ScaleW-1:0] pct, input int target,
                             input int src_pct, input int snk_pct);
        bin_t   b;
        pixel_t px;
        int     made;
        int     tries;
        int     lo;
        int     lo2;
        int     span;
        int     sel;
        int     five;
        five = int'(swc_pkg::FiveDb);
        write_scale(pct);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        made  = 0;
        tries = 0;
        while (made < target && tries < 4 * target)
        begin
            sel = $urandom_range(99);
            b.row_last = ($urandom_range(7) == 0);
            if (sel < 70)
            begin
                lo   = int'($urandom_range(30000)) - 20000;
                span = int'($urandom_range(12000, 1));
                lo2  = lo + int'($urandom_range(4000)) - 2000;
                b.gmin  = clip16(lo);
                b.gmax  = clip16(lo + span - five);
                b.lmin  = clip16(lo2);
                b.lmax  = clip16(lo2 + int'($urandom_range(12000, 1)));
                b.level = clip16(lo - span / 8 + int'($urandom_range(span + span / 4)));
            end
            else if (sel < 80)
            begin
                lo = int'($urandom_range(60000)) - 30000;
                b.gmin  = clip16(lo);
                b.gmax  = clip16(lo - five + int'($urandom_range(3)) - 1);
                b.lmin  = clip16(lo);
                b.lmax  = clip16(lo + int'($urandom_range(3)) - 1);
                b.level = clip16(lo + int'($urandom_range(4)) - 2);
            end
            else
            begin
                b.level = 16'($urandom);
                b.gmax  = 16'($urandom);
                b.gmin  = 16'($urandom);
                b.lmax  = 16'($urandom);
                b.lmin  = 16'($urandom);
            end
            if (predict_pixel(b, pct, px))
                made = made + 1;
            tries = tries + 1;
            bin_q.push_back(b);
        end
        wait_drained();
    endtask

    initial
    begin
        wait (cycles >= LIMIT_CYCLES);
        $display("timeout after %0d cycles, %0d pixels still expected", cycles, pixel_q.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset scale (0): limits chosen so the index equals the bin level
        src_idle_pct = 30;
        snk_idle_pct = 30;
        push_bin(-1, -1025, 0, 32767, -32768, 0);
        push_bin(0, -1025, 0, -32768, 32767, 0);
        push_bin(1, -1025, 0, 0, 0, 0);
        push_bin(50, -1025, 0, 0, 0, 1);
        push_bin(51, -1025, 0, 0, 0, 0);
        push_bin(52, -1025, 0, 0, 0, 0);
        push_bin(101, -1025, 0, 0, 0, 0);
        push_bin(102, -1025, 0, 0, 0, 1);
        push_bin(103, -1025, 0, 0, 0, 0);
        push_bin(152, -1025, 0, 0, 0, 0);
        push_bin(153, -1025, 0, 0, 0, 0);
        push_bin(154, -1025, 0, 0, 0, 1);
        push_bin(203, -1025, 0, 0, 0, 0);
        push_bin(204, -1025, 0, 0, 0, 0);
        push_bin(205, -1025, 0, 0, 0, 0);
        push_bin(254, -1025, 0, 0, 0, 1);
        push_bin(255, -1025, 0, 0, 0, 0);
        push_bin(256, -1025, 0, 0, 0, 0);
        // full-scale fields, empty and negative ranges, one-step range
        push_bin(32767, 32767, -32768, 32767, 32767, 1);
        push_bin(-32768, 32767, -32768, -32768, -32768, 0);
        push_bin(0, -32768, 32767, -32768, 32767, 1);
        push_bin(5, -1280, 0, 0, 0, 0);
        push_bin(0, -1279, 0, 0, 0, 0);
        push_bin(1, -1279, 0, 0, 0, 1);
        wait_drained();

        run_phase(7'd100, PHASE_BINS, 15, 40);
        run_phase(7'd37, PHASE_BINS, 0, 25);
        run_phase(7'd127, PHASE_BINS, 40, 0);
        run_phase(7'd1, PHASE_BINS, 20, 20);
        run_phase(7'($urandom_range(99, 2)), PHASE_BINS, 10, 60);
        run_phase(7'd0, PHASE_BINS, 0, 0);

        $display("%0d bins sent (%0d with an empty range), %0d pixels checked, %0d errors",
                 n_bins, n_dropped, n_pixels, n_bad + pixel_q.size());
        $display("%0d scale writes incl. 0, 100 and saturating 127; knot and clamp edges hit",
                 n_cfg);
        if (pixel_q.size() != 0)
            $display("%0d expected pixels never arrived", pixel_q.size());
        if (n_bad == 0 && pixel_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
